// ===== sv/ptt_pkg.sv =====
// Shared types and constants for the periodic task timer table.
// Holds the slot record, transaction payloads and op/kind/status codes.
// No dependencies.
package ptt_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_TICK    = 3'd1;
  localparam logic [2:0] OP_REMOVE  = 3'd2;
  localparam logic [2:0] OP_EXISTS  = 3'd3;
  localparam logic [2:0] OP_CLEANUP = 3'd4;

  localparam logic [2:0] KIND_CREATE  = 3'd0;
  localparam logic [2:0] KIND_FIRE    = 3'd1;
  localparam logic [2:0] KIND_MATCH   = 3'd2;
  localparam logic [2:0] KIND_CLEANUP = 3'd3;
  localparam logic [2:0] KIND_TICK    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic               busy;
    logic signed [24:0] countdown;
    logic [23:0]        reload_period;
    logic [15:0]        repeats_left;
    logic [31:0]        key;
    logic signed [15:0] owner_id;
    logic [7:0]         owner_kind;
  } slot_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [23:0]        period_ms;
    logic [15:0]        repeat_total;
    logic [31:0]        callback_key;
    logic signed [15:0] owner_id;
    logic [7:0]         owner_kind;
    logic [1:0]         match_mode;
    logic [15:0]        elapsed_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [4:0]         slot_index;
    logic [31:0]        fired_key;
    logic signed [15:0] fired_owner_id;
    logic [7:0]         fired_owner_kind;
    logic [1:0]         status;
    logic [5:0]         freed_count;
    logic               last;
  } rsp_t;

  function automatic slot_t free_slot();
    slot_t s;
    s               = '0;
    s.owner_id      = '1;
    return s;
  endfunction

endpackage

// ===== sv/periodic_task_timer_table_core.sv =====
// Top level of the periodic task timer table: control and slot chain.
// Depends on ptt_pkg and ptt_cell.
//
// Requests enter on req_valid/req_stall/req_data, results leave on
// rsp_valid/rsp_stall/rsp_data. The slots sit in a ring of cells that
// rotates by one each step; the slot at the head is examined and written
// back at the tail, so every op visits the slots in ascending order.
// Create, tick, exists and cleanup go once round the ring and then emit
// the final result; remove goes round twice (find the highest match,
// then free it) and then emits its result. An unknown op is accepted
// and gives no result. One request is worked at a time; req_stall is high
// while a request is in progress.
// Tick emits one fire transaction per expiring slot during the rotation,
// then a tick-done transaction with last set.
// Results go through one output register; while it is stalled the ring
// holds, so nothing is lost. Reset frees all slots at once.
module periodic_task_timer_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ptt_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ptt_pkg::rsp_t rsp_data
);
  import ptt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0]       state;
  req_t             req;
  logic [IDX_W-1:0] cnt;
  logic             pass;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [5:0]       freed;

  slot_t chain_q [SLOT_COUNT];
  slot_t tail;
  slot_t head;
  logic  step;
  logic  can_load;
  logic  rsp_load;

  logic               m;
  logic signed [25:0] diff;
  logic               fire;
  logic               hit_set;
  logic               freed_inc;
  rsp_t               fire_rsp;
  rsp_t               final_rsp;

  assign head      = chain_q[0];
  assign can_load  = !rsp_valid || !rsp_stall;
  assign step      = (state == S_SCAN) && can_load;
  assign req_stall = (state != S_IDLE);
  assign rsp_load  = (step && fire) || ((state == S_FINAL) && can_load);

  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      if (g == SLOT_COUNT - 1) begin : g_tail
        ptt_cell u_cell (.clk(clk), .rst(rst), .shift(step), .d(tail), .q(chain_q[g]));
      end else begin : g_mid
        ptt_cell u_cell (.clk(clk), .rst(rst), .shift(step), .d(chain_q[g+1]),
                         .q(chain_q[g]));
      end
    end
  endgenerate

  always_comb begin
    m = head.busy && (head.key == req.callback_key) && (head.owner_id == req.owner_id)
        && (head.owner_kind == req.owner_kind);
    if (req.match_mode != 2'd0) begin
      m = m && (head.reload_period == req.period_ms);
    end
    if (req.match_mode[1]) begin
      m = m && (head.repeats_left == req.repeat_total);
    end
    diff      = {head.countdown[24], head.countdown} - $signed({10'd0, req.elapsed_ms});
    tail      = head;
    fire      = 1'b0;
    hit_set   = 1'b0;
    freed_inc = 1'b0;
    case (req.op)
      OP_CREATE: begin
        if (!head.busy && !hit) begin
          tail.busy          = 1'b1;
          tail.countdown     = $signed({1'b0, req.period_ms});
          tail.reload_period = req.period_ms;
          tail.repeats_left  = req.repeat_total;
          tail.key           = req.callback_key;
          tail.owner_id      = req.owner_id;
          tail.owner_kind    = req.owner_kind;
          hit_set            = 1'b1;
        end
      end
      OP_TICK: begin
        if (head.busy && head.countdown != '0) begin
          if (diff > 26'sd0) begin
            tail.countdown = diff[24:0];
          end else begin
            fire = 1'b1;
            if (head.repeats_left == 16'd1) begin
              tail = free_slot();
            end else begin
              if (head.repeats_left != 16'd0) begin
                tail.repeats_left = head.repeats_left - 16'd1;
              end
              tail.countdown = $signed({1'b0, head.reload_period});
            end
          end
        end
      end
      OP_REMOVE, OP_EXISTS: begin
        if (!pass) begin
          hit_set = m;
        end else if (req.op == OP_REMOVE && hit && hit_idx == cnt) begin
          tail = free_slot();
        end
      end
      OP_CLEANUP: begin
        if (head.busy && head.owner_id == req.owner_id
            && head.owner_kind == req.owner_kind) begin
          tail      = free_slot();
          freed_inc = 1'b1;
        end
      end
      default: begin
      end
    endcase

    fire_rsp                  = '0;
    fire_rsp.kind             = KIND_FIRE;
    fire_rsp.slot_index       = 5'(cnt);
    fire_rsp.fired_key        = head.key;
    fire_rsp.fired_owner_id   = head.owner_id;
    fire_rsp.fired_owner_kind = head.owner_kind;

    final_rsp      = '0;
    final_rsp.last = 1'b1;
    case (req.op)
      OP_CREATE: begin
        final_rsp.kind = KIND_CREATE;
        if (hit) begin
          final_rsp.slot_index = 5'(hit_idx);
        end else begin
          final_rsp.status = ST_FULL;
        end
      end
      OP_TICK: begin
        final_rsp.kind = KIND_TICK;
      end
      OP_CLEANUP: begin
        final_rsp.kind        = KIND_CLEANUP;
        final_rsp.freed_count = freed;
      end
      default: begin
        final_rsp.kind = KIND_MATCH;
        if (hit) begin
          final_rsp.slot_index = 5'(hit_idx);
        end else begin
          final_rsp.status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      pass      <= 1'b0;
      hit       <= 1'b0;
      freed     <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp_data  <= (state == S_FINAL) ? final_rsp : fire_rsp;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req   <= req_data;
            cnt   <= '0;
            pass  <= 1'b0;
            hit   <= 1'b0;
            freed <= '0;
            if (req_data.op inside {OP_CREATE, OP_TICK, OP_REMOVE, OP_EXISTS, OP_CLEANUP}) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (step) begin
            if (hit_set) begin
              hit     <= 1'b1;
              hit_idx <= cnt;
            end
            if (freed_inc) begin
              freed <= freed + 6'd1;
            end
            if (cnt == IDX_W'(SLOT_COUNT - 1)) begin
              cnt <= '0;
              if (req.op == OP_REMOVE && !pass) begin
                pass <= 1'b1;
              end else begin
                state <= S_FINAL;
              end
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_FINAL: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/ptt_cell.sv =====
// One timer slot of the rotating slot chain.
// Depends on ptt_pkg for the slot record.
module ptt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  ptt_pkg::slot_t d,
  output ptt_pkg::slot_t q
);
  import ptt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= free_slot();
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== verif/periodic_task_timer_table_core_checker.sv =====
// Checker for the periodic task timer table: watches both channels,
// predicts results from its own slot table and compares them in order.
// Depends on ptt_pkg.
`timescale 1ns / 1ps
module periodic_task_timer_table_core_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  ptt_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  ptt_pkg::rsp_t rsp_data,
  output int            fail_count,
  output int            pending
);
  import ptt_pkg::*;

  slot_t        table_q [SLOT_COUNT];
  rsp_t         expected_rsps [$];

  function automatic rsp_t make_rsp(logic [2:0] k, logic [4:0] idx, logic [1:0] st,
                                    logic [5:0] freed, logic lst);
    rsp_t r;
    r = '0;
    r.kind = k;
    r.slot_index = idx;
    r.status = st;
    r.freed_count = freed;
    r.last = lst;
    return r;
  endfunction

  task automatic predict(input req_t rq);
    int          found;
    int          n;
    logic        hit;
    rsp_t        r;
    found = -1;
    case (rq.op)
      OP_CREATE: begin
        for (int i = 0; i < SLOT_COUNT; i++)
          if (!table_q[i].busy && found < 0) found = i;
        if (found < 0) begin
          expected_rsps.push_back(make_rsp(KIND_CREATE, 0, ST_FULL, 0, 1));
        end else begin
          table_q[found].busy = 1;
          table_q[found].countdown = {1'b0, rq.period_ms};
          table_q[found].reload_period = rq.period_ms;
          table_q[found].repeats_left = rq.repeat_total;
          table_q[found].key = rq.callback_key;
          table_q[found].owner_id = rq.owner_id;
          table_q[found].owner_kind = rq.owner_kind;
          expected_rsps.push_back(make_rsp(KIND_CREATE, found[4:0], ST_OK, 0, 1));
        end
      end
      OP_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!table_q[i].busy || table_q[i].countdown == 0) continue;
          table_q[i].countdown = table_q[i].countdown - $signed({9'd0, rq.elapsed_ms});
          if (table_q[i].countdown > 0) continue;
          r = make_rsp(KIND_FIRE, i[4:0], ST_OK, 0, 0);
          r.fired_key = table_q[i].key;
          r.fired_owner_id = table_q[i].owner_id;
          r.fired_owner_kind = table_q[i].owner_kind;
          expected_rsps.push_back(r);
          if (table_q[i].repeats_left != 0) begin
            table_q[i].repeats_left--;
            if (table_q[i].repeats_left == 0) begin
              table_q[i] = free_slot();
              continue;
            end
          end
          table_q[i].countdown = {1'b0, table_q[i].reload_period};
        end
        expected_rsps.push_back(make_rsp(KIND_TICK, 0, ST_OK, 0, 1));
      end
      OP_REMOVE, OP_EXISTS: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          hit = table_q[i].busy && table_q[i].key == rq.callback_key &&
                table_q[i].owner_id == rq.owner_id && table_q[i].owner_kind == rq.owner_kind;
          if (rq.match_mode >= 1) hit = hit && table_q[i].reload_period == rq.period_ms;
          if (rq.match_mode >= 2) hit = hit && table_q[i].repeats_left == rq.repeat_total;
          if (hit) found = i;
        end
        if (found < 0) begin
          expected_rsps.push_back(make_rsp(KIND_MATCH, 0, ST_NOT_FOUND, 0, 1));
        end else begin
          if (rq.op == OP_REMOVE) table_q[found] = free_slot();
          expected_rsps.push_back(make_rsp(KIND_MATCH, found[4:0], ST_OK, 0, 1));
        end
      end
      OP_CLEANUP: begin
        n = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (table_q[i].busy && table_q[i].owner_id == rq.owner_id &&
              table_q[i].owner_kind == rq.owner_kind) begin
            table_q[i] = free_slot();
            n++;
          end
        expected_rsps.push_back(make_rsp(KIND_CLEANUP, 0, ST_OK, n[5:0], 1));
      end
      default: ;
    endcase
  endtask

  assign pending = expected_rsps.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) table_q[i] = free_slot();
      expected_rsps.delete();
      fail_count <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result %h", $time, rsp_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (want !== rsp_data) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req_valid && !req_stall) predict(req_data);
    end
  end
endmodule

// ===== verif/periodic_task_timer_table_core_test.sv =====
// Testbench top for the periodic task timer table core.
// Drives requests and result stalls; the checker predicts and compares.
// Depends on ptt_pkg, the core and periodic_task_timer_table_core_checker.
`timescale 1ns / 1ps
module periodic_task_timer_table_core_test;
  import ptt_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  rsp_t rsp_data;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   hold_off = 0;

  localparam int WATCHDOG = 20000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  periodic_task_timer_table_core i_dut (.*);

  periodic_task_timer_table_core_checker i_checker (.*);

  // Recent create keys so that matches often hit.
  req_t made [$];

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  task automatic send(input req_t rq);
    int g;
    g = gap_len();
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1;
    req_data  <= rq;
    do @(posedge clk); while (req_stall);
    if (rq.op == OP_CREATE) begin
      made.push_back(rq);
      if (made.size() > 40) void'(made.pop_front());
    end
  endtask

  function automatic req_t rand_req();
    req_t r;
    int   sel;
    r = '0;
    r.period_ms = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 300));
    r.repeat_total = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
    r.callback_key = $urandom();
    r.owner_id = ($urandom_range(0, 3) == 0) ? -16'sd1 : 16'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) r.owner_id = 16'($urandom());
    r.owner_kind = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 1));
    r.match_mode = 2'($urandom_range(0, 3));
    r.elapsed_ms = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 200));
    sel = $urandom_range(0, 99);
    if (sel < 40) r.op = OP_CREATE;
    else if (sel < 65) r.op = OP_TICK;
    else if (sel < 78) r.op = OP_REMOVE;
    else if (sel < 90) r.op = OP_EXISTS;
    else if (sel < 97) r.op = OP_CLEANUP;
    else r.op = 3'($urandom_range(5, 7));
    if ((r.op == OP_REMOVE || r.op == OP_EXISTS || r.op == OP_CLEANUP) &&
        made.size() > 0 && $urandom_range(0, 3) != 0) begin
      req_t m;
      m = made[$urandom_range(0, made.size() - 1)];
      r.callback_key = m.callback_key;
      r.owner_id = m.owner_id;
      r.owner_kind = m.owner_kind;
      r.period_ms = m.period_ms;
      if ($urandom_range(0, 1)) r.repeat_total = m.repeat_total;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) rsp_stall <= 0;
    else if (hold_off) rsp_stall <= 1;
    else rsp_stall <= ($urandom_range(0, 19) == 0) ? 1 : ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_t rq;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    rq = '0;
    rq.op = OP_TICK; send(rq);
    rq.op = OP_CREATE; rq.period_ms = 0; rq.callback_key = '1; rq.owner_id = -1;
    rq.owner_kind = 8'hFF; send(rq);
    rq.period_ms = 24'hFFFFFF; rq.repeat_total = 16'hFFFF; rq.owner_id = 16'sh7FFF;
    rq.callback_key = 0; rq.owner_kind = 0; send(rq);
    rq.period_ms = 10; rq.repeat_total = 1; rq.callback_key = 32'hA5A5_5A5A;
    rq.owner_id = 5; rq.owner_kind = 3; send(rq);
    rq.repeat_total = 0; send(rq);
    rq.op = OP_TICK; rq.elapsed_ms = 16'hFFFF; send(rq);
    rq.elapsed_ms = 3; send(rq);
    for (int m = 0; m < 4; m++) begin
      rq.op = OP_EXISTS; rq.match_mode = 2'(m); send(rq);
    end
    rq.op = OP_REMOVE; rq.match_mode = 1; send(rq);
    rq.op = OP_REMOVE; send(rq);
    rq.op = 3'd7; send(rq);
    rq.op = OP_CREATE; rq.period_ms = 1;
    for (int i = 0; i < 33; i++) send(rq);
    rq.op = OP_TICK; rq.elapsed_ms = 1;
    hold_off <= 1;
    fork
      begin repeat (400) @(posedge clk); hold_off <= 0; end
      begin send(rq); send(rq); end
    join
    rq.op = OP_CLEANUP; send(rq);
    for (int i = 0; i < 270; i++) send(rand_req());
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== periodic_task_timer_table_core.f =====
sv/ptt_pkg.sv
sv/ptt_cell.sv
sv/periodic_task_timer_table_core.sv
verif/periodic_task_timer_table_core_checker.sv
verif/periodic_task_timer_table_core_test.sv
